/* rtl/ars_pkg.sv */
package ars_pkg;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_PRESET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
  } md_ctrl_t;

endpackage

/* rtl/auto_range_scaler.sv */
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | req_type, sample, target_first/second, presets
// out     | output    | out_valid / out_stall | scaled_out, range_low, range_high
//
// A sample runs a bit-serial shift-add multiply and a restoring divide, SAMPLE_WIDTH+1
// steps each, between one accepted transaction and the next. Quotient overflow skips the
// divide; a zero range skips both; clear, preset and unknown requests go straight to DONE.
// Reset clears tracked range, seed flag, state and output valid.
// in_stall is high while an item is in progress; a result waits in DONE while out is stalled.
module auto_range_scaler #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_target_first,
  input  logic signed [SAMPLE_WIDTH-1:0] in_target_second,
  input  logic signed [SAMPLE_WIDTH-1:0] in_preset_low,
  input  logic signed [SAMPLE_WIDTH-1:0] in_preset_high,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_scaled_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_range_low,
  output logic signed [SAMPLE_WIDTH-1:0] out_range_high
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int CNT_W = $clog2(W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W);
  localparam logic [W:0] CAP = {1'b1, {W{1'b0}}};

  ars_pkg::state_t   state_r, state_nxt;
  ars_pkg::md_ctrl_t md_ctrl;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                in_acc;
  logic                out_free;
  logic signed [W-1:0] sample_r, t1_r, t2_r, tmin_r;
  logic signed [W-1:0] scaled_r;
  logic                zero_r, ovf_r;
  logic                out_valid_r;
  logic signed [W-1:0] out_scaled_r, out_low_r, out_high_r;

  logic signed [W-1:0] trk_min, trk_max, rng_low, rng_high;
  logic [W:0]          rin, rout, delta;
  logic                first_le;
  logic [W:0]          quot;
  logic                md_ovf;
  logic [W:0]          qc;
  logic signed [W+1:0] sum;
  logic signed [W-1:0] sat_val;

  function automatic logic [W:0] absdiff(logic signed [W-1:0] a, logic signed [W-1:0] b);
    logic [W:0] df;
    df = {a[W-1], a} - {b[W-1], b};
    return df[W] ? (~df + 1'b1) : df;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != ars_pkg::ST_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  ars_track #(.W(W)) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (in_acc),
    .req         (in_req_type),
    .sample      (in_sample),
    .preset_low  (in_preset_low),
    .preset_high (in_preset_high),
    .track_min   (trk_min),
    .track_max   (trk_max),
    .range_low   (rng_low),
    .range_high  (rng_high)
  );

  always_comb begin
    first_le = t1_r <= t2_r;
    rin      = absdiff(trk_max, trk_min);
    rout     = absdiff(t2_r, t1_r);
    delta    = first_le ? absdiff(sample_r, trk_min) : absdiff(sample_r, trk_max);
  end

  ars_muldiv #(.W(W)) u_muldiv (
    .clk     (clk),
    .ctrl    (md_ctrl),
    .mul_a   (delta),
    .mul_b   (rout),
    .divisor (rin),
    .quot    (quot),
    .ovf     (md_ovf)
  );

  always_comb begin
    if (zero_r)                  qc = '0;
    else if (ovf_r || quot > CAP) qc = CAP;
    else                         qc = quot;
    sum = $signed({1'b0, qc}) + $signed({{2{tmin_r[W-1]}}, tmin_r});
    if (!sum[W+1] && (sum[W:W-1] != 2'b00))     sat_val = {1'b0, {(W-1){1'b1}}};
    else if (sum[W+1] && (sum[W:W-1] != 2'b11)) sat_val = {1'b1, {(W-1){1'b0}}};
    else                                         sat_val = sum[W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    md_ctrl   = '0;
    unique case (state_r)
      ars_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_req_type == ars_pkg::REQ_SAMPLE) ? ars_pkg::ST_SETUP
                                                           : ars_pkg::ST_DONE;
        end
      end
      ars_pkg::ST_SETUP: begin
        md_ctrl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = (rin == '0) ? ars_pkg::ST_FIN : ars_pkg::ST_MUL;
      end
      ars_pkg::ST_MUL: begin
        md_ctrl.mul_step = 1'b1;
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = ars_pkg::ST_CHECK;
      end
      ars_pkg::ST_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = md_ovf ? ars_pkg::ST_FIN : ars_pkg::ST_DIV;
      end
      ars_pkg::ST_DIV: begin
        md_ctrl.div_step = 1'b1;
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = ars_pkg::ST_FIN;
      end
      ars_pkg::ST_FIN: begin
        state_nxt = ars_pkg::ST_DONE;
      end
      ars_pkg::ST_DONE: begin
        if (out_free) state_nxt = ars_pkg::ST_IDLE;
      end
      default: state_nxt = ars_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ars_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ars_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                         out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
      t1_r     <= in_target_first;
      t2_r     <= in_target_second;
      scaled_r <= '0;
    end
    if (state_r == ars_pkg::ST_SETUP) begin
      tmin_r <= first_le ? t1_r : t2_r;
      zero_r <= rin == '0;
      ovf_r  <= 1'b0;
    end
    if (state_r == ars_pkg::ST_CHECK) ovf_r <= md_ovf;
    if (state_r == ars_pkg::ST_FIN) scaled_r <= sat_val;
    if (state_r == ars_pkg::ST_DONE && out_free) begin
      out_scaled_r <= scaled_r;
      out_low_r    <= rng_low;
      out_high_r   <= rng_high;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scaled_out = out_scaled_r;
  assign out_range_low  = out_low_r;
  assign out_range_high = out_high_r;

`ifndef SYNTH
  a_range_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_low <= out_range_high))
    else $error("result range not ordered");

  a_nonsample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req_type != ars_pkg::REQ_SAMPLE)
      |=> (state_r == ars_pkg::ST_DONE) && (scaled_r == '0))
    else $error("clear/preset/unknown request did not give zero");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ars_pkg::ST_DIV) |-> !md_ovf)
    else $error("divide remainder not below divisor");

  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ars_pkg::ST_MUL) && (cnt_r == LAST) |=> (state_r == ars_pkg::ST_CHECK))
    else $error("multiply pass length wrong");
`endif

endmodule

/* rtl/ars_track.sv */
module ars_track #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic [1:0]          req,
  input  logic signed [W-1:0] sample,
  input  logic signed [W-1:0] preset_low,
  input  logic signed [W-1:0] preset_high,
  output logic signed [W-1:0] track_min,
  output logic signed [W-1:0] track_max,
  output logic signed [W-1:0] range_low,
  output logic signed [W-1:0] range_high
);

  logic signed [W-1:0] min_r, min_nxt;
  logic signed [W-1:0] max_r, max_nxt;
  logic                seeded_r, seeded_nxt;

  always_comb begin
    min_nxt    = min_r;
    max_nxt    = max_r;
    seeded_nxt = seeded_r;
    if (upd) begin
      unique case (req)
        ars_pkg::REQ_SAMPLE: begin
          if (!seeded_r && (min_r == max_r)) begin
            min_nxt    = sample;
            max_nxt    = sample;
            seeded_nxt = 1'b1;
          end else begin
            if (sample < min_r) min_nxt = sample;
            if (sample > max_r) max_nxt = sample;
          end
        end
        ars_pkg::REQ_CLEAR: begin
          min_nxt    = '0;
          max_nxt    = '0;
          seeded_nxt = 1'b0;
        end
        ars_pkg::REQ_PRESET: begin
          min_nxt = preset_low;
          max_nxt = preset_high;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      max_r    <= '0;
      seeded_r <= 1'b0;
    end else begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  assign track_min  = min_r;
  assign track_max  = max_r;
  assign range_low  = (min_r <= max_r) ? min_r : max_r;
  assign range_high = (min_r <= max_r) ? max_r : min_r;

endmodule

/* rtl/ars_muldiv.sv */
module ars_muldiv #(
  parameter int W = 16
) (
  input  logic             clk,
  input  ars_pkg::md_ctrl_t ctrl,
  input  logic [W:0]       mul_a,
  input  logic [W:0]       mul_b,
  input  logic [W:0]       divisor,
  output logic [W:0]       quot,
  output logic             ovf
);

  // {hi,lo} is the product after the multiply pass, then remainder/quotient
  logic [W:0]   hi_r;
  logic [W:0]   lo_r;
  logic [W:0]   mul_b_r;
  logic [W:0]   div_r;
  logic [W+1:0] msum;
  logic [W+1:0] dtrial;
  logic [W+1:0] ddiff;
  logic         dge;
  logic [W:0]   dnext;

  always_comb begin
    msum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mul_b_r} : '0);
    dtrial = {hi_r, lo_r[W]};
    ddiff  = dtrial - {1'b0, div_r};
    dge    = dtrial >= {1'b0, div_r};
    dnext  = dge ? ddiff[W:0] : dtrial[W:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hi_r    <= '0;
      lo_r    <= mul_a;
      mul_b_r <= mul_b;
      div_r   <= divisor;
    end else if (ctrl.mul_step) begin
      hi_r <= msum[W+1:1];
      lo_r <= {msum[0], lo_r[W:1]};
    end else if (ctrl.div_step) begin
      hi_r <= dnext;
      lo_r <= {lo_r[W-1:0], dge};
    end
  end

  assign quot = lo_r;
  assign ovf  = hi_r >= div_r;

endmodule

/* bench/ars_checker.sv */
module ars_checker
  import ars_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic signed [W-1:0] in_sample,
  input  logic signed [W-1:0] in_target_first,
  input  logic signed [W-1:0] in_target_second,
  input  logic signed [W-1:0] in_preset_low,
  input  logic signed [W-1:0] in_preset_high,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [W-1:0] out_scaled_out,
  input  logic signed [W-1:0] out_range_low,
  input  logic signed [W-1:0] out_range_high,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [W-1:0] scaled;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
  } scaled_range_t;

  scaled_range_t awaited_ranges[$];
  longint        trk_min;
  longint        trk_max;
  bit            trk_seeded;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint span(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic longint clamp_w(input longint v);
    longint top;
    top = (longint'(1) << (W - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  task automatic note_fault(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // advance the tracked range by one transaction and queue the result it gives
  task automatic absorb(input logic [1:0] rq, input longint s, input longint t1,
                        input longint t2, input longint pl, input longint ph);
    scaled_range_t r;
    longint        rin;
    longint        rout;
    longint        q;
    longint        base;
    r.scaled = '0;
    case (rq)
      REQ_SAMPLE: begin
        if (!trk_seeded && trk_min == trk_max) begin
          trk_seeded = 1'b1;
          trk_min    = s;
          trk_max    = s;
        end
        if (s < trk_min) trk_min = s;
        if (s > trk_max) trk_max = s;
        rin  = span(trk_max, trk_min);
        rout = span(t2, t1);
        base = (t1 <= t2) ? t1 : t2;
        if (rin == 0) begin
          r.scaled = W'(base);
        end else begin
          q = ((t1 <= t2) ? span(s, trk_min) : span(s, trk_max)) * rout / rin;
          if (q > (longint'(1) << W)) q = longint'(1) << W;
          r.scaled = W'(clamp_w(q + base));
        end
      end
      REQ_CLEAR: begin
        trk_min    = 0;
        trk_max    = 0;
        trk_seeded = 1'b0;
      end
      REQ_PRESET: begin
        trk_min = pl;
        trk_max = ph;
      end
      default: ;
    endcase
    r.lo = W'((trk_min <= trk_max) ? trk_min : trk_max);
    r.hi = W'((trk_min <= trk_max) ? trk_max : trk_min);
    awaited_ranges.push_back(r);
  endtask

  always @(posedge clk) begin
    scaled_range_t want;
    if (!rst_n) begin
      trk_min    = 0;
      trk_max    = 0;
      trk_seeded = 1'b0;
      awaited_ranges.delete();
    end else begin
      if (in_valid && !in_stall)
        absorb(in_req_type, longint'(in_sample), longint'(in_target_first),
               longint'(in_target_second), longint'(in_preset_low),
               longint'(in_preset_high));
      if (out_valid && !out_stall) begin
        if (awaited_ranges.size() == 0) begin
          note_fault("result transaction with nothing outstanding");
        end else begin
          want = awaited_ranges.pop_front();
          if (out_scaled_out !== want.scaled)
            note_fault($sformatf("scaled_out got %0d want %0d", out_scaled_out, want.scaled));
          if (out_range_low !== want.lo)
            note_fault($sformatf("range_low got %0d want %0d", out_range_low, want.lo));
          if (out_range_high !== want.hi)
            note_fault($sformatf("range_high got %0d want %0d", out_range_high, want.hi));
        end
      end
    end
    pending <= awaited_ranges.size();
  end

endmodule

/* bench/tb_auto_range_scaler.sv */
module tb_auto_range_scaler;
  import ars_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SW         = 16;
  localparam int         LIMIT      = 1000000;
  localparam int         N_RANDOM   = 1400;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic signed [SW-1:0] in_sample;
  logic signed [SW-1:0] in_target_first;
  logic signed [SW-1:0] in_target_second;
  logic signed [SW-1:0] in_preset_low;
  logic signed [SW-1:0] in_preset_high;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SW-1:0] out_scaled_out;
  logic signed [SW-1:0] out_range_low;
  logic signed [SW-1:0] out_range_high;
  int                   fault_count;
  int                   outstanding;
  int                   cyc = 0;

  auto_range_scaler #(.SAMPLE_WIDTH(SW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_sample(in_sample), .in_target_first(in_target_first),
    .in_target_second(in_target_second), .in_preset_low(in_preset_low),
    .in_preset_high(in_preset_high),
    .out_valid(out_valid), .out_stall(out_stall), .out_scaled_out(out_scaled_out),
    .out_range_low(out_range_low), .out_range_high(out_range_high)
  );

  ars_checker #(.W(SW)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_sample(in_sample), .in_target_first(in_target_first),
    .in_target_second(in_target_second), .in_preset_low(in_preset_low),
    .in_preset_high(in_preset_high),
    .out_valid(out_valid), .out_stall(out_stall), .out_scaled_out(out_scaled_out),
    .out_range_low(out_range_low), .out_range_high(out_range_high),
    .errors(fault_count), .pending(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] any_word();
    return SW'($urandom());
  endfunction

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(SW-1){1'b0}}};
      1:       return {1'b0, {(SW-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // optional idle gap first, then hold the transaction until it is taken
  task automatic offer(input logic [1:0] rq, input logic signed [SW-1:0] s,
                       input logic signed [SW-1:0] t1, input logic signed [SW-1:0] t2,
                       input logic signed [SW-1:0] pl, input logic signed [SW-1:0] ph,
                       input bit calm);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (r >= 95)      gap = $urandom_range(20, 60);
      else if (r >= 70) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= rq;
    in_sample        <= s;
    in_target_first  <= t1;
    in_target_second <= t2;
    in_preset_low    <= pl;
    in_preset_high   <= ph;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver: short and long stalls, calm stretches, one long hold-off
  initial begin
    int r;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && cyc > 20000) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end else if (((cyc / 3000) % 4) == 2 || r < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  initial begin
    int                   i;
    int                   pick;
    int                   k;
    int                   ctr;
    bit                   calm;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] t1;
    logic signed [SW-1:0] t2;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_req_type      <= REQ_SAMPLE;
    in_sample        <= '0;
    in_target_first  <= '0;
    in_target_second <= '0;
    in_preset_low    <= '0;
    in_preset_high   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // seed from reset, zero range, full-scale ends, inversion, equal targets
    offer(REQ_SAMPLE, 0, -32768, 32767, 0, 0, 0);
    offer(REQ_SAMPLE, 32767, -32768, 32767, 0, 0, 0);
    offer(REQ_SAMPLE, -32768, -32768, 32767, 0, 0, 0);
    offer(REQ_SAMPLE, 0, 32767, -32768, 0, 0, 0);
    offer(REQ_SAMPLE, 1234, 100, 100, 0, 0, 0);
    offer(REQ_UNUSED, -1, -1, -1, -1, -1, 0);
    offer(REQ_CLEAR, -1, -1, -1, -1, -1, 0);
    offer(REQ_SAMPLE, -5, 10, -10, 0, 0, 0);
    offer(REQ_SAMPLE, -5, 10, -10, 0, 0, 0);
    offer(REQ_SAMPLE, 7, 0, 1000, 0, 0, 0);
    // inverted preset collapses on the next sample
    offer(REQ_PRESET, 0, 0, 0, 100, -100, 0);
    offer(REQ_SAMPLE, 0, -32768, 32767, 0, 0, 0);
    offer(REQ_PRESET, 0, 0, 0, 32767, -32768, 0);
    offer(REQ_UNUSED, 0, 0, 0, 0, 0, 0);
    offer(REQ_SAMPLE, 32767, 32767, -32768, 0, 0, 0);
    // equal preset while unseeded reseeds
    offer(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    offer(REQ_PRESET, 0, 0, 0, 50, 50, 0);
    offer(REQ_SAMPLE, -300, 0, 255, 0, 0, 0);
    offer(REQ_PRESET, 0, 0, 0, -32768, 32767, 0);
    offer(REQ_SAMPLE, 0, 32767, -32768, 0, 0, 0);
    offer(REQ_SAMPLE, -1, -1, 0, 0, 0, 0);
    offer(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    offer(REQ_PRESET, 0, 0, 0, 0, 0, 0);
    offer(REQ_SAMPLE, 9, -32768, 32767, 0, 0, 0);

    ctr = 0;
    for (i = 0; i < N_RANDOM; i++) begin
      calm = ((i / 150) % 4) == 1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        ctr = $urandom_range(0, 60000) - 30000;
        offer(REQ_CLEAR, any_word(), any_word(), any_word(), any_word(), any_word(), calm);
      end else if (pick < 10) begin
        ctr = $urandom_range(0, 60000) - 30000;
        s   = any_word();
        if ($urandom_range(0, 9) < 3)
          offer(REQ_PRESET, any_word(), any_word(), any_word(), s, s, calm);
        else
          offer(REQ_PRESET, any_word(), any_word(), any_word(), s, any_word(), calm);
      end else if (pick < 13) begin
        offer(REQ_UNUSED, any_word(), any_word(), any_word(), any_word(), any_word(), calm);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 45)      s = any_word();
        else if (k < 85) s = SW'(ctr + $urandom_range(0, 64) - 32);
        else             s = pick_extreme();
        k = $urandom_range(0, 99);
        if (k < 60) begin
          t1 = any_word();
          t2 = any_word();
        end else if (k < 72) begin
          t1 = any_word();
          t2 = t1;
        end else if (k < 88) begin
          t1 = SW'($urandom_range(0, 255));
          t2 = SW'($urandom_range(0, 255));
        end else begin
          t1 = pick_extreme();
          t2 = pick_extreme();
        end
        offer(REQ_SAMPLE, s, t1, t2, any_word(), any_word(), calm);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * SW + 20) @(posedge clk);
    if (fault_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ars_pkg.sv
rtl/ars_track.sv
rtl/ars_muldiv.sv
rtl/auto_range_scaler.sv
bench/ars_checker.sv
bench/tb_auto_range_scaler.sv
